FILE: hw/rtl/counter_bank_max_tracker_macros.svh
// Assertion macros for the counter bank checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef COUNTER_BANK_MAX_TRACKER_MACROS_SVH
`define COUNTER_BANK_MAX_TRACKER_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define CBMT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("counter bank check failed");

// Next-cycle implication, off while reset is asserted
`define CBMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("counter bank check failed");

`endif

FILE: hw/rtl/cbmt_pkg.sv
// Shared constants and types for the counter bank with maximum tracking.
// No dependencies.
package cbmt_pkg;

  localparam int NUM_COUNTERS = 256;
  localparam int COUNT_LIMIT  = 1023;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 8;
  localparam int CNT_W  = 10;
  localparam int HIST_W = 9;

  localparam int BKT_DEPTH = COUNT_LIMIT + 1;
  localparam int BKT_W     = $clog2(BKT_DEPTH);
  localparam int CLR_DEPTH = (NUM_COUNTERS > BKT_DEPTH) ? NUM_COUNTERS : BKT_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_INC = 2'd0,
    CMD_DEC = 2'd1,
    CMD_CLR = 2'd2,
    CMD_QRY = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDC,
    ST_HOLD,
    ST_HNEW,
    ST_SRD,
    ST_SCHK
  } state_t;

endpackage

FILE: hw/rtl/counter_bank_max_tracker.sv
// Counter bank with value histogram and running maximum: top level.
// Depends on cbmt_pkg.
//
//  channel | ports                                              | handshake
//  --------+----------------------------------------------------+------------------
//  in      | in_command, in_counter_index                       | start && !busy
//  out     | out_counter_value, out_max_value, out_num_at_max,  | out_valid, 1 cycle
//          | out_limit_flag                                     |
//
// A query, a saturated step or a clear of a zero counter is answered in ST_RDC; an
// increment, decrement or clear that moves a counter passes ST_HOLD and ST_HNEW.
// A clear that empties the top bucket searches the histogram downward, one bucket
// per ST_SRD and ST_SCHK pass, through the single histogram read port. After
// reset, busy stays high in ST_CLEAR, which writes every counter and bucket. One
// item is worked on at a time; the receiver cannot stall, so results never wait.
module counter_bank_max_tracker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [cbmt_pkg::CMD_W-1:0]  in_command,
  input  logic [cbmt_pkg::IDX_W-1:0]  in_counter_index,
  output logic                       out_valid,
  output logic [cbmt_pkg::CNT_W-1:0]  out_counter_value,
  output logic [cbmt_pkg::CNT_W-1:0]  out_max_value,
  output logic [cbmt_pkg::HIST_W-1:0] out_num_at_max,
  output logic                       out_limit_flag
);
  import cbmt_pkg::*;

  logic [CNT_W-1:0]  cnt_mem  [NUM_COUNTERS];
  logic [HIST_W-1:0] hist_mem [BKT_DEPTH];

  logic             cnt_we;
  logic [IDX_W-1:0] cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0] cnt_wdata, cnt_rd_r;

  logic              hist_we;
  logic [BKT_W-1:0]  hist_waddr, hist_raddr;
  logic [HIST_W-1:0] hist_wdata, hist_rd_r;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  v_r, v_nxt;
  logic [CNT_W-1:0]  nv_r, nv_nxt;
  logic [HIST_W-1:0] hold_r, hold_nxt;
  logic [HIST_W-1:0] hnew_r, hnew_nxt;
  logic [CNT_W-1:0]  max_r, max_nxt;
  logic [HIST_W-1:0] maxcnt_r, maxcnt_nxt;
  logic [CNT_W-1:0]  m_r, m_nxt;
  logic [CLR_W-1:0]  clr_r, clr_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  out_value_r, out_value_nxt;
  logic [CNT_W-1:0]  out_max_r, out_max_nxt;
  logic [HIST_W-1:0] out_num_r, out_num_nxt;
  logic              out_flag_r, out_flag_nxt;

  // scratch for the decision cycles
  logic              in_range;
  logic              change;
  logic              lim;
  logic [CNT_W-1:0]  nv_calc;
  logic [CNT_W-1:0]  new_max;
  logic [HIST_W-1:0] new_cnt;

  // counter store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_r <= cnt_mem[cnt_raddr];
  end

  // histogram: one write, one registered read
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rd_r <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      max_r       <= '0;
      maxcnt_r    <= HIST_W'(NUM_COUNTERS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      max_r       <= max_nxt;
      maxcnt_r    <= maxcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    idx_r       <= idx_nxt;
    v_r         <= v_nxt;
    nv_r        <= nv_nxt;
    hold_r      <= hold_nxt;
    hnew_r      <= hnew_nxt;
    m_r         <= m_nxt;
    out_value_r <= out_value_nxt;
    out_max_r   <= out_max_nxt;
    out_num_r   <= out_num_nxt;
    out_flag_r  <= out_flag_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    v_nxt         = v_r;
    nv_nxt        = nv_r;
    hold_nxt      = hold_r;
    hnew_nxt      = hnew_r;
    max_nxt       = max_r;
    maxcnt_nxt    = maxcnt_r;
    m_nxt         = m_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_max_nxt   = out_max_r;
    out_num_nxt   = out_num_r;
    out_flag_nxt  = out_flag_r;

    cnt_we     = 1'b0;
    cnt_waddr  = idx_r;
    cnt_wdata  = nv_r;
    cnt_raddr  = in_counter_index;
    hist_we    = 1'b0;
    hist_waddr = v_r;
    hist_wdata = '0;
    hist_raddr = v_r;

    in_range = 32'(idx_r) < NUM_COUNTERS;
    change   = 1'b0;
    lim      = 1'b0;
    nv_calc  = cnt_rd_r;
    new_max  = max_r;
    new_cnt  = maxcnt_r;

    case (state_r)
      ST_CLEAR: begin
        // sweep: bucket zero holds every counter, all else empty
        cnt_we     = 32'(clr_r) < NUM_COUNTERS;
        cnt_waddr  = clr_r[IDX_W-1:0];
        cnt_wdata  = '0;
        hist_we    = 32'(clr_r) < BKT_DEPTH;
        hist_waddr = clr_r[BKT_W-1:0];
        hist_wdata = (clr_r == '0) ? HIST_W'(NUM_COUNTERS) : '0;
        if (32'(clr_r) == CLR_DEPTH - 1) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start) begin
          cmd_nxt   = cmd_t'(in_command);
          idx_nxt   = in_counter_index;
          state_nxt = ST_RDC;
        end
      end

      ST_RDC: begin
        case (cmd_r)
          CMD_INC: begin
            if (cnt_rd_r == CNT_W'(COUNT_LIMIT)) begin
              lim = 1'b1;
            end else begin
              change  = 1'b1;
              nv_calc = cnt_rd_r + 1'b1;
            end
          end
          CMD_DEC: begin
            if (cnt_rd_r == '0) begin
              lim = 1'b1;
            end else begin
              change  = 1'b1;
              nv_calc = cnt_rd_r - 1'b1;
            end
          end
          CMD_CLR: begin
            change  = cnt_rd_r != '0;
            nv_calc = '0;
          end
          default: begin
          end
        endcase
        if (in_range && change) begin
          v_nxt      = cnt_rd_r;
          nv_nxt     = nv_calc;
          hist_raddr = cnt_rd_r;
          state_nxt  = ST_HOLD;
        end else begin
          out_valid_nxt = 1'b1;
          out_value_nxt = in_range ? cnt_rd_r : '0;
          out_flag_nxt  = in_range && lim;
          out_max_nxt   = max_r;
          out_num_nxt   = maxcnt_r;
          state_nxt     = ST_IDLE;
        end
      end

      ST_HOLD: begin
        // drop the counter from its old bucket, fetch the new bucket
        hold_nxt   = hist_rd_r - 1'b1;
        hist_we    = 1'b1;
        hist_waddr = v_r;
        hist_wdata = hist_rd_r - 1'b1;
        hist_raddr = nv_r;
        cnt_we     = 1'b1;
        state_nxt  = ST_HNEW;
      end

      ST_HNEW: begin
        hnew_nxt   = hist_rd_r + 1'b1;
        hist_we    = 1'b1;
        hist_waddr = nv_r;
        hist_wdata = hist_rd_r + 1'b1;
        case (cmd_r)
          CMD_INC: new_max = (nv_r > max_r) ? nv_r : max_r;
          CMD_DEC: new_max = (v_r == max_r && hold_r == '0) ? nv_r : max_r;
          default: new_max = max_r;
        endcase
        if (new_max == nv_r) begin
          new_cnt = hist_rd_r + 1'b1;
        end else if (new_max == v_r) begin
          new_cnt = hold_r;
        end else begin
          new_cnt = maxcnt_r;
        end
        if (cmd_r == CMD_CLR && v_r == max_r && hold_r == '0 && v_r != CNT_W'(1)) begin
          // top bucket emptied: walk down from the bucket below it
          m_nxt     = v_r - 1'b1;
          state_nxt = ST_SRD;
        end else begin
          if (cmd_r == CMD_CLR && v_r == max_r && hold_r == '0) begin
            new_max = '0;
            new_cnt = hist_rd_r + 1'b1;
          end
          max_nxt       = new_max;
          maxcnt_nxt    = new_cnt;
          out_valid_nxt = 1'b1;
          out_value_nxt = nv_r;
          out_flag_nxt  = 1'b0;
          out_max_nxt   = new_max;
          out_num_nxt   = new_cnt;
          state_nxt     = ST_IDLE;
        end
      end

      ST_SRD: begin
        hist_raddr = m_r;
        state_nxt  = ST_SCHK;
      end

      ST_SCHK: begin
        if (hist_rd_r != '0 || m_r == CNT_W'(1)) begin
          new_max = (hist_rd_r != '0) ? m_r : '0;
          new_cnt = (hist_rd_r != '0) ? hist_rd_r : hnew_r;
          max_nxt       = new_max;
          maxcnt_nxt    = new_cnt;
          out_valid_nxt = 1'b1;
          out_value_nxt = nv_r;
          out_flag_nxt  = 1'b0;
          out_max_nxt   = new_max;
          out_num_nxt   = new_cnt;
          state_nxt     = ST_IDLE;
        end else begin
          m_nxt     = m_r - 1'b1;
          state_nxt = ST_SRD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy              = state_r != ST_IDLE;
  assign out_valid         = out_valid_r;
  assign out_counter_value = out_value_r;
  assign out_max_value     = out_max_r;
  assign out_num_at_max    = out_num_r;
  assign out_limit_flag    = out_flag_r;

endmodule

FILE: hw/rtl/cbmt_checker.sv
// Port-level checks for the counter bank with maximum tracking, and its bind.
// Depends on cbmt_pkg and counter_bank_max_tracker_macros.svh.
`include "counter_bank_max_tracker_macros.svh"

module cbmt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [cbmt_pkg::CNT_W-1:0]  out_counter_value,
  input logic [cbmt_pkg::CNT_W-1:0]  out_max_value,
  input logic [cbmt_pkg::HIST_W-1:0] out_num_at_max,
  input logic                       out_limit_flag
);
  import cbmt_pkg::*;

  // an accepted beat holds the block busy while it works
  `CBMT_ASSERT_NEXT(a_busy_after_beat, start && !busy, busy)
  // one result per beat, never in back-to-back cycles
  `CBMT_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  // the top bucket is never empty
  `CBMT_ASSERT_IMPL(a_max_bucket_full, out_valid, out_num_at_max != '0)
  // no counter exceeds the maximum
  `CBMT_ASSERT_IMPL(a_value_le_max, out_valid, out_counter_value <= out_max_value)
  // the limit flag only at either end of the range
  `CBMT_ASSERT_IMPL(a_flag_at_edge, out_valid && out_limit_flag,
                    out_counter_value == '0 || out_counter_value == CNT_W'(COUNT_LIMIT))

endmodule

bind counter_bank_max_tracker cbmt_checker u_cbmt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_counter_value (out_counter_value),
  .out_max_value     (out_max_value),
  .out_num_at_max    (out_num_at_max),
  .out_limit_flag    (out_limit_flag)
);
